// ----- rtl/gyro_offset_calibrate_and_correct_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the gyro offset calibration block
// Shorthand for clocked properties on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef GYRO_OFFSET_CALIBRATE_AND_CORRECT_MACROS_SVH
`define GYRO_OFFSET_CALIBRATE_AND_CORRECT_MACROS_SVH

// Same-cycle implication.
`define GOC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define GOC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/goc_pkg.sv -----
// ----------------------------------------------------------------------------
// goc_pkg
// Shared widths, codes, control types and saturation for gyro offset
// calibration and correction.
// ----------------------------------------------------------------------------
package goc_pkg;

	// Number of samples averaged per calibration; must be a power of two.
	localparam int CAL_SAMPLES = 128;
	// Gyro axes that take part in calibration (1 to 3).
	localparam int AXES        = 3;

	localparam int DATA_W    = 16;
	localparam int CAL_SHIFT = $clog2(CAL_SAMPLES);
	localparam int CAL_HALF  = CAL_SAMPLES / 2;
	localparam int SUM_W     = DATA_W + CAL_SHIFT;
	localparam int Q_W       = SUM_W + 1 - CAL_SHIFT;
	localparam int WIDE_W    = Q_W + 1;
	localparam int CNT_W     = $clog2(CAL_SAMPLES + 1);

	typedef enum logic {
		REQ_SAMPLE = 1'b0,
		REQ_START  = 1'b1
	} req_t;

	typedef enum logic [2:0] {
		ST_UPDATED     = 3'd0,
		ST_READ_FAIL   = 3'd1,
		ST_CALIBRATING = 3'd2,
		ST_CAL_DONE    = 3'd3,
		ST_CAL_ABORTED = 3'd4
	} status_t;

	typedef struct packed {
		logic clr;
		logic acc;
		logic fin;
	} axis_ctl_t;

	// Clamp a wide signed value to the 16-bit range.
	function automatic logic signed [DATA_W-1:0] sat16(input logic signed [WIDE_W-1:0] v);
		logic pos_ovf;
		logic neg_ovf;
		pos_ovf = !v[WIDE_W-1] && (|v[WIDE_W-2:DATA_W-1]);
		neg_ovf = v[WIDE_W-1] && !(&v[WIDE_W-2:DATA_W-1]);
		if (pos_ovf) begin
			sat16 = {1'b0, {(DATA_W-1){1'b1}}};
		end else if (neg_ovf) begin
			sat16 = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			sat16 = v[DATA_W-1:0];
		end
	endfunction

endpackage

// ----- rtl/gyro_offset_calibrate_and_correct.sv -----
// ----------------------------------------------------------------------------
// gyro_offset_calibrate_and_correct
// Gyro zero-rate offset calibration and correction for a six-axis sample stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request: a sensor sample
//   (req_type = 0) with read_ok and six raw counts, or a start-calibration
//   request (req_type = 1). Output channel (out_valid / out_stall) returns
//   exactly one result per request: six held/corrected counts and a status.
//   The request enters the input register when it is accepted and its result
//   is then loaded into the result register, where out_valid rises.
//   Throughput is one request per cycle while out_stall is low; the
//   offset arithmetic (add, round, shift, saturate) completes within the
//   result stage.
//   After a start request the next CAL_SAMPLES good samples are summed; the
//   last one loads the offsets. A failed read during calibration aborts it.
//   Reset clears offsets, sums, sample count and held outputs to zero and
//   empties both stages. While a result is held and out_stall is high, the
//   result register holds; the input register still takes a request if it
//   is empty, then in_stall rises until the result is taken.
// ----------------------------------------------------------------------------
`include "gyro_offset_calibrate_and_correct_macros.svh"

module gyro_offset_calibrate_and_correct (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              req_type,
	input  logic                              read_ok,
	input  logic signed [goc_pkg::DATA_W-1:0] gyro_x_raw,
	input  logic signed [goc_pkg::DATA_W-1:0] gyro_y_raw,
	input  logic signed [goc_pkg::DATA_W-1:0] gyro_z_raw,
	input  logic signed [goc_pkg::DATA_W-1:0] accel_x_raw,
	input  logic signed [goc_pkg::DATA_W-1:0] accel_y_raw,
	input  logic signed [goc_pkg::DATA_W-1:0] accel_z_raw,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [goc_pkg::DATA_W-1:0] gyro_x_out,
	output logic signed [goc_pkg::DATA_W-1:0] gyro_y_out,
	output logic signed [goc_pkg::DATA_W-1:0] gyro_z_out,
	output logic signed [goc_pkg::DATA_W-1:0] accel_x_out,
	output logic signed [goc_pkg::DATA_W-1:0] accel_y_out,
	output logic signed [goc_pkg::DATA_W-1:0] accel_z_out,
	output logic [2:0]                        status
);

	localparam logic [goc_pkg::CNT_W-1:0] CNT_LAST = goc_pkg::CNT_W'(goc_pkg::CAL_SAMPLES - 1);

	// input stage
	logic                              valid_s1;
	goc_pkg::req_t                     req_s1;
	logic                              ok_s1;
	logic signed [goc_pkg::DATA_W-1:0] gyro_s1  [3];
	logic signed [goc_pkg::DATA_W-1:0] accel_s1 [3];

	// result stage and calibration state
	logic                              out_valid_q;
	goc_pkg::status_t                  status_q;
	logic signed [goc_pkg::DATA_W-1:0] gyro_q  [3];
	logic signed [goc_pkg::DATA_W-1:0] accel_q [3];
	logic                              cal_q;
	logic [goc_pkg::CNT_W-1:0]         count_q;

	logic                              out_free;
	logic                              adv;
	logic                              load_in;
	goc_pkg::axis_ctl_t                ctl;
	goc_pkg::status_t                  status_nx;
	logic                              cal_nx;
	logic [goc_pkg::CNT_W-1:0]         count_nx;
	logic                              upd_out;
	logic signed [goc_pkg::DATA_W-1:0] corr [3];

	assign out_free = !out_valid_q || !out_stall;
	assign adv      = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign load_in  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_in) begin
			req_s1      <= goc_pkg::req_t'(req_type);
			ok_s1       <= read_ok;
			gyro_s1[0]  <= gyro_x_raw;
			gyro_s1[1]  <= gyro_y_raw;
			gyro_s1[2]  <= gyro_z_raw;
			accel_s1[0] <= accel_x_raw;
			accel_s1[1] <= accel_y_raw;
			accel_s1[2] <= accel_z_raw;
		end
	end

	// request decode against the calibration state
	always_comb begin
		ctl       = '0;
		status_nx = goc_pkg::ST_UPDATED;
		cal_nx    = cal_q;
		count_nx  = count_q;
		upd_out   = 1'b0;
		priority if (req_s1 == goc_pkg::REQ_START) begin
			ctl.clr   = 1'b1;
			cal_nx    = 1'b1;
			count_nx  = '0;
			status_nx = goc_pkg::ST_CALIBRATING;
		end else if (cal_q && !ok_s1) begin
			ctl.clr   = 1'b1;
			cal_nx    = 1'b0;
			count_nx  = '0;
			status_nx = goc_pkg::ST_CAL_ABORTED;
		end else if (cal_q) begin
			ctl.acc = 1'b1;
			if (count_q == CNT_LAST) begin
				ctl.fin   = 1'b1;
				cal_nx    = 1'b0;
				count_nx  = '0;
				status_nx = goc_pkg::ST_CAL_DONE;
			end else begin
				count_nx  = count_q + 1'b1;
				status_nx = goc_pkg::ST_CALIBRATING;
			end
		end else if (!ok_s1) begin
			status_nx = goc_pkg::ST_READ_FAIL;
		end else begin
			upd_out   = 1'b1;
			status_nx = goc_pkg::ST_UPDATED;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_axis
		goc_pkg::axis_ctl_t ctl_ax;

		// axes beyond AXES never calibrate and keep a zero offset
		always_comb begin
			ctl_ax     = '0;
			ctl_ax.clr = adv && ctl.clr;
			if (i < goc_pkg::AXES) begin
				ctl_ax.acc = adv && ctl.acc;
				ctl_ax.fin = adv && ctl.fin;
			end
		end

		goc_axis u_axis (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl_ax),
			.raw    (gyro_s1[i]),
			.corr   (corr[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			status_q    <= goc_pkg::ST_UPDATED;
			cal_q       <= 1'b0;
			count_q     <= '0;
			gyro_q      <= '{default: '0};
			accel_q     <= '{default: '0};
		end else if (out_free) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				status_q <= status_nx;
				cal_q    <= cal_nx;
				count_q  <= count_nx;
				if (upd_out) begin
					gyro_q  <= corr;
					accel_q <= accel_s1;
				end
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign gyro_x_out  = gyro_q[0];
	assign gyro_y_out  = gyro_q[1];
	assign gyro_z_out  = gyro_q[2];
	assign accel_x_out = accel_q[0];
	assign accel_y_out = accel_q[1];
	assign accel_z_out = accel_q[2];
	assign status      = status_q;

	`GOC_ASSERT_NOW(a_cnt_idle, !cal_q, count_q == '0, "sample count nonzero outside calibration")
	`GOC_ASSERT_NOW(a_status_cal, status_q == goc_pkg::ST_CALIBRATING, cal_q,
		"calibrating status without calibration")
	`GOC_ASSERT_NOW(a_status_end,
		status_q == goc_pkg::ST_CAL_DONE || status_q == goc_pkg::ST_CAL_ABORTED, !cal_q,
		"calibration still running after done or abort")
	`GOC_ASSERT_NEXT(a_start_cal, adv && req_s1 == goc_pkg::REQ_START,
		cal_q && out_valid_q && count_q == '0, "start request did not open calibration")

endmodule

// ----- rtl/goc_axis.sv -----
// ----------------------------------------------------------------------------
// goc_axis
// One gyro axis: calibration sum, rounded offset and saturated correction.
// ----------------------------------------------------------------------------
module goc_axis (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  goc_pkg::axis_ctl_t                   ctl,
	input  logic signed [goc_pkg::DATA_W-1:0]    raw,
	output logic signed [goc_pkg::DATA_W-1:0]    corr
);

	logic signed [goc_pkg::SUM_W-1:0]  sum_q;
	logic signed [goc_pkg::DATA_W-1:0] off_q;
	logic signed [goc_pkg::SUM_W-1:0]  sum_nx;
	logic                              neg;
	logic        [goc_pkg::SUM_W-1:0]  mag;
	logic        [goc_pkg::SUM_W:0]    rnd;
	logic        [goc_pkg::Q_W-1:0]    q;
	logic signed [goc_pkg::WIDE_W-1:0] q_ext;
	logic signed [goc_pkg::WIDE_W-1:0] off_wide;
	logic signed [goc_pkg::DATA_W-1:0] off_nx;

	assign sum_nx = sum_q + goc_pkg::SUM_W'(raw);
	assign neg    = sum_nx[goc_pkg::SUM_W-1];
	assign mag    = neg ? goc_pkg::SUM_W'(-sum_nx) : goc_pkg::SUM_W'(sum_nx);
	// round half away from zero on the magnitude, then shift
	assign rnd    = {1'b0, mag} + (goc_pkg::SUM_W + 1)'(goc_pkg::CAL_HALF);
	assign q      = rnd[goc_pkg::SUM_W:goc_pkg::CAL_SHIFT];
	assign q_ext  = $signed({1'b0, q});
	// offset is minus the average
	assign off_wide = neg ? q_ext : -q_ext;
	assign off_nx   = goc_pkg::sat16(off_wide);

	assign corr = goc_pkg::sat16(goc_pkg::WIDE_W'(raw) + goc_pkg::WIDE_W'(off_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			off_q <= '0;
		end else if (ctl.clr) begin
			sum_q <= '0;
			off_q <= '0;
		end else if (ctl.acc) begin
			sum_q <= sum_nx;
			if (ctl.fin) begin
				off_q <= off_nx;
			end
		end
	end

endmodule

// ----- tb/gyro_offset_calibrate_and_correct_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_offset_calibrate_and_correct_test
// Drives sensor samples and calibration requests into the gyro offset block
// and predicts every result from a local copy of its sums, offsets and held
// outputs. Each result is checked field by field, in order of acceptance.
// Directed tests cover the extremes, offset rounding and saturation, abort
// and restart. A random phase follows with mostly complete calibrations and
// bursts of corrected samples. Both channels idle at random.
// ----------------------------------------------------------------------------
module gyro_offset_calibrate_and_correct_test;

	localparam int CLK_PERIOD   = 8;
	localparam int RESET_CYCLES = 6;
	localparam int RANDOM_ITEMS = 350;
	localparam int IDLE_PCT     = 9;
	localparam int DRAIN_CYCLES = 8;
	localparam int STALL_LIMIT  = 1000;

	typedef struct packed {
		goc_pkg::req_t req;
		logic          ok;
		logic [5:0][15:0] raw;	// 0..2 gyro x/y/z, 3..5 accel x/y/z
	} sensor_req_t;

	typedef struct packed {
		logic [5:0][15:0] val;
		goc_pkg::status_t st;
	} sensor_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic        req_type  = 1'b0;
	logic        read_ok   = 1'b0;
	logic [15:0] gyro_x_raw  = '0;
	logic [15:0] gyro_y_raw  = '0;
	logic [15:0] gyro_z_raw  = '0;
	logic [15:0] accel_x_raw = '0;
	logic [15:0] accel_y_raw = '0;
	logic [15:0] accel_z_raw = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] gyro_x_out;
	logic [15:0] gyro_y_out;
	logic [15:0] gyro_z_out;
	logic [15:0] accel_x_out;
	logic [15:0] accel_y_out;
	logic [15:0] accel_z_out;
	logic [2:0]  status;

	// Predictor state
	longint           axis_sum [3];
	longint           gyro_offset [3];
	int               cal_count;
	bit               cal_active;
	logic [5:0][15:0] held_vals;

	sensor_result_t expected_results[$];

	int idle_pct  = IDLE_PCT;
	int stall_pct = IDLE_PCT;
	int n_sent;
	int n_checked;
	int n_errors;
	int n_cal_done;
	int n_cal_aborted;
	int n_corrected;
	int n_read_fail;
	int quiet_cycles = 0;

	string out_name [6] = '{"gyro_x_out", "gyro_y_out", "gyro_z_out",
		"accel_x_out", "accel_y_out", "accel_z_out"};

	gyro_offset_calibrate_and_correct u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.read_ok     (read_ok),
		.gyro_x_raw  (gyro_x_raw),
		.gyro_y_raw  (gyro_y_raw),
		.gyro_z_raw  (gyro_z_raw),
		.accel_x_raw (accel_x_raw),
		.accel_y_raw (accel_y_raw),
		.accel_z_raw (accel_z_raw),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.gyro_x_out  (gyro_x_out),
		.gyro_y_out  (gyro_y_out),
		.gyro_z_out  (gyro_z_out),
		.accel_x_out (accel_x_out),
		.accel_y_out (accel_y_out),
		.accel_z_out (accel_z_out),
		.status      (status)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic [15:0] clamp_s16(input longint v);
		if (v > 32767) begin
			return 16'h7fff;
		end else if (v < -32768) begin
			return 16'h8000;
		end
		return v[15:0];
	endfunction

	function automatic void clear_calibration();
		for (int a = 0; a < 3; a++) begin
			axis_sum[a]    = 0;
			gyro_offset[a] = 0;
		end
		cal_count = 0;
	endfunction

	// Advance the predicted state by one accepted request and queue its result.
	function automatic void predict_result(input sensor_req_t r);
		sensor_result_t res;
		longint         mag;
		longint         q;
		if (r.req == goc_pkg::REQ_START) begin
			clear_calibration();
			cal_active = 1'b1;
			res.st = goc_pkg::ST_CALIBRATING;
		end else if (cal_active) begin
			if (!r.ok) begin
				clear_calibration();
				cal_active = 1'b0;
				res.st = goc_pkg::ST_CAL_ABORTED;
				n_cal_aborted++;
			end else begin
				for (int a = 0; a < goc_pkg::AXES; a++)
					axis_sum[a] += $signed(r.raw[a]);
				cal_count++;
				if (cal_count >= goc_pkg::CAL_SAMPLES) begin
					// Round half away from zero, then negate and clamp
					for (int a = 0; a < goc_pkg::AXES; a++) begin
						mag = (axis_sum[a] < 0) ? -axis_sum[a] : axis_sum[a];
						q = (mag + goc_pkg::CAL_SAMPLES / 2) / goc_pkg::CAL_SAMPLES;
						if (axis_sum[a] < 0)
							q = -q;
						gyro_offset[a] = $signed(clamp_s16(-q));
					end
					cal_active = 1'b0;
					cal_count = 0;
					res.st = goc_pkg::ST_CAL_DONE;
					n_cal_done++;
				end else begin
					res.st = goc_pkg::ST_CALIBRATING;
				end
			end
		end else if (!r.ok) begin
			res.st = goc_pkg::ST_READ_FAIL;
			n_read_fail++;
		end else begin
			for (int a = 0; a < 3; a++)
				held_vals[a] = clamp_s16(longint'($signed(r.raw[a])) + gyro_offset[a]);
			for (int a = 3; a < 6; a++)
				held_vals[a] = r.raw[a];
			res.st = goc_pkg::ST_UPDATED;
			n_corrected++;
		end
		res.val = held_vals;
		expected_results.push_back(res);
	endfunction

	function automatic sensor_req_t mk_sample(input logic ok, input logic [15:0] gx,
			input logic [15:0] gy, input logic [15:0] gz, input logic [15:0] ax,
			input logic [15:0] ay, input logic [15:0] az);
		sensor_req_t r;
		r.req = goc_pkg::REQ_SAMPLE;
		r.ok  = ok;
		r.raw = {az, ay, ax, gz, gy, gx};
		return r;
	endfunction

	function automatic sensor_req_t rand_req(input goc_pkg::req_t kind, input logic ok);
		sensor_req_t r;
		r.req = kind;
		r.ok  = ok;
		for (int a = 0; a < 6; a++)
			r.raw[a] = 16'($urandom);
		return r;
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_req(input sensor_req_t r);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		req_type    <= r.req;
		read_ok     <= r.ok;
		gyro_x_raw  <= r.raw[0];
		gyro_y_raw  <= r.raw[1];
		gyro_z_raw  <= r.raw[2];
		accel_x_raw <= r.raw[3];
		accel_y_raw <= r.raw[4];
		accel_z_raw <= r.raw[5];
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_result(r);
		n_sent++;
		@(negedge clk);
	endtask

	task automatic test_passthrough_extremes();
		send_req(mk_sample(1'b1, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
		send_req(mk_sample(1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
		send_req(mk_sample(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
		send_req(mk_sample(1'b1, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
		send_req(mk_sample(1'b1, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa));
		send_req(mk_sample(1'b1, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555));
		// A failed read holds the previous outputs
		send_req(rand_req(goc_pkg::REQ_SAMPLE, 1'b0));
		send_req(rand_req(goc_pkg::REQ_SAMPLE, 1'b1));
	endtask

	// X averages -32768, so its offset saturates; Y and Z average exactly half
	// a count in magnitude and round away from zero in opposite directions.
	task automatic test_calibration_edges();
		idle_pct  = 0;
		stall_pct = 0;
		send_req(rand_req(goc_pkg::REQ_START, 1'b0));
		for (int i = 0; i < goc_pkg::CAL_SAMPLES; i++)
			send_req(mk_sample(1'b1, 16'h8000, (i == 0) ? 16'd64 : 16'd0,
				(i == goc_pkg::CAL_SAMPLES - 1) ? -16'sd64 : 16'd0,
				16'($urandom), 16'($urandom), 16'($urandom)));
		send_req(mk_sample(1'b1, 16'h7fff, 16'h8000, 16'h7fff, 16'h0001, 16'h0002, 16'h0003));
		send_req(mk_sample(1'b1, 16'h8000, 16'h0000, 16'hffff, 16'h8000, 16'h7fff, 16'h0000));
		send_req(mk_sample(1'b1, 16'h0000, 16'h7fff, 16'h8000, 16'hffff, 16'h8000, 16'h7fff));
		idle_pct  = IDLE_PCT;
		stall_pct = IDLE_PCT;
	endtask

	task automatic test_abort_and_restart();
		send_req(rand_req(goc_pkg::REQ_START, 1'b1));
		repeat (3)
			send_req(rand_req(goc_pkg::REQ_SAMPLE, 1'b1));
		send_req(rand_req(goc_pkg::REQ_SAMPLE, 1'b0));
		// Offsets were cleared by the start request and stay at zero
		send_req(rand_req(goc_pkg::REQ_SAMPLE, 1'b1));
		send_req(rand_req(goc_pkg::REQ_START, 1'b0));
		repeat (2)
			send_req(rand_req(goc_pkg::REQ_SAMPLE, 1'b1));
		send_req(rand_req(goc_pkg::REQ_START, 1'b1));
		send_req(rand_req(goc_pkg::REQ_SAMPLE, 1'b1));
		send_req(rand_req(goc_pkg::REQ_SAMPLE, 1'b0));
		send_req(rand_req(goc_pkg::REQ_SAMPLE, 1'b0));
		send_req(rand_req(goc_pkg::REQ_SAMPLE, 1'b1));
	endtask

	task automatic test_random_traffic();
		int          start_count;
		int          abort_at;
		int          restart_at;
		int          amp;
		int          bias [3];
		sensor_req_t r;
		start_count = n_sent;
		while (n_sent - start_count < RANDOM_ITEMS) begin
			if ($urandom_range(99) < 55) begin
				// Calibration with a steady bias and bounded noise, sometimes aborted or restarted
				for (int a = 0; a < 3; a++) begin
					case ($urandom_range(3))
						0: bias[a] = -32768;
						1: bias[a] = 32767;
						2: bias[a] = $signed(16'($urandom));
						default: bias[a] = $urandom_range(400) - 200;
					endcase
				end
				amp        = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 300);
				abort_at   = ($urandom_range(9) == 0) ?
					$urandom_range(goc_pkg::CAL_SAMPLES - 1) : -1;
				restart_at = ($urandom_range(19) == 0) ?
					$urandom_range(goc_pkg::CAL_SAMPLES - 1) : -1;
				send_req(rand_req(goc_pkg::REQ_START, 1'($urandom)));
				for (int k = 0; k < goc_pkg::CAL_SAMPLES; k++) begin
					if (k == abort_at) begin
						send_req(rand_req(goc_pkg::REQ_SAMPLE, 1'b0));
						break;
					end
					if (k == restart_at) begin
						send_req(rand_req(goc_pkg::REQ_START, 1'($urandom)));
					end else begin
						r = rand_req(goc_pkg::REQ_SAMPLE, 1'b1);
						for (int a = 0; a < 3; a++)
							r.raw[a] = clamp_s16(bias[a] + int'($urandom_range(2 * amp)) - amp);
						send_req(r);
					end
				end
			end else begin
				repeat ($urandom_range(4, 24))
					send_req(rand_req(goc_pkg::REQ_SAMPLE, $urandom_range(99) >= 12));
			end
		end
	endtask

	always @(negedge clk)
		out_stall <= arst_n && ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin : check_results
		sensor_result_t   want;
		logic [5:0][15:0] got;
		if (arst_n && out_valid && !out_stall) begin
			got = {accel_z_out, accel_y_out, accel_x_out, gyro_z_out, gyro_y_out, gyro_x_out};
			if (expected_results.size() == 0) begin
				$error("result with none expected: status %0d", status);
				n_errors++;
			end else begin
				want = expected_results.pop_front();
				n_checked++;
				for (int i = 0; i < 6; i++) begin
					if (got[i] !== want.val[i]) begin
						$error("%s: expected %0d, got %0d", out_name[i],
							$signed(want.val[i]), $signed(got[i]));
						n_errors++;
					end
				end
				if (status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					n_errors++;
				end
			end
		end
	end

	// Stop a hung run: count cycles in which neither channel moves a request
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("[gyro_offset_calibrate_and_correct] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		clear_calibration();
		cal_active = 1'b0;
		held_vals  = '0;
		repeat (RESET_CYCLES)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_passthrough_extremes();
		test_calibration_edges();
		test_abort_and_restart();
		test_random_traffic();

		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		$display("Sent %0d requests, checked %0d results with %0d mismatches.",
			n_sent, n_checked, n_errors);
		$display("Calibrations completed %0d, aborted %0d; %0d corrected samples, %0d failed reads.",
			n_cal_done, n_cal_aborted, n_corrected, n_read_fail);
		if (n_errors == 0) begin
			$display("[gyro_offset_calibrate_and_correct] OK");
		end else begin
			$display("[gyro_offset_calibrate_and_correct] ERROR");
		end
		$finish;
	end

endmodule

// ----- gyro_offset_calibrate_and_correct.f -----
+incdir+rtl
rtl/goc_pkg.sv
rtl/goc_axis.sv
rtl/gyro_offset_calibrate_and_correct.sv
tb/gyro_offset_calibrate_and_correct_test.sv
